>>> src/ppr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_pkg
// Request and status codes for the priority page replacer.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int KeyW = 32;
  localparam int IdW  = 32;

  typedef logic [1:0] opcode_t;
  typedef logic [2:0] status_t;

  localparam opcode_t OP_SET    = 2'd0;
  localparam opcode_t OP_UNSET  = 2'd1;
  localparam opcode_t OP_LOOKUP = 2'd2;
  localparam opcode_t OP_CLEAR  = 2'd3;

  localparam status_t ST_RAISED     = 3'd0;
  localparam status_t ST_INSERTED   = 3'd1;
  localparam status_t ST_REPLACED   = 3'd2;
  localparam status_t ST_REMOVED    = 3'd3;
  localparam status_t ST_NOT_FOUND  = 3'd4;
  localparam status_t ST_NOT_RAISED = 3'd5;
  localparam status_t ST_PRESENT    = 3'd6;

  // signed compare of two Q16.16 keys held as raw bits
  function automatic logic key_gt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    key_gt = $signed(a) > $signed(b);
  endfunction

endpackage

>>> src/priority_page_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_page_replacer
// Page table with an indexed binary min-heap on priorities, one request
// at a time under a small sequencer.
// ----------------------------------------------------------------------------
// Requests come in on s_t*: s_tuser carries the opcode, s_tdata the page id
// and the signed Q16.16 priority. Each request gives one response on m_t*:
// m_tuser carries status and the evicted flag, m_tdata the evicted id.
// A request other than clear first scans the id table one slot per cycle,
// then, where it changes the heap, walks it level by level in a sift:
// read the heap order, read the keys, then compare and write back.
// s_tready is high only while the block is idle.
// The response sits in an output register; if the receiver stalls, the
// block holds it, takes one more request and keeps that response back
// until the held one is gone.
// Reset empties the table at once (valid bits cleared, count zero).
// ----------------------------------------------------------------------------
module priority_page_replacer
  import ppr_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // page_id [31:0], priority_req [63:32]
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // evicted_id [31:0]
  output logic [3:0]  m_tuser    // status [2:0], evicted [3]
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_HIT, S_R1, S_R2, S_U1, S_U2, S_U3, S_MISS, S_V1, S_V2,
    S_AP, S_SD0, S_SD1, S_SD2, S_SU0, S_SU1, S_SU2, S_FIX, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_NONE, PH_UNSET, PH_REPL} phase_t;

  function automatic logic [SW-1:0] pa(input logic [CW:0] p);
    logic [CW:0] t;
    t  = p - 1'b1;
    pa = t[SW-1:0];
  endfunction

  state_t            state;
  phase_t            phase;
  opcode_t           op;
  logic [IdW-1:0]    id;
  logic [KeyW-1:0]   key;
  status_t           status;
  logic              evicted;
  logic [IdW-1:0]    evid;
  logic [CW-1:0]     scan;
  logic [CW-1:0]     count;
  logic [CW-1:0]     k;
  logic [SW-1:0]     slot;
  logic [SW-1:0]     free;
  logic              free_ok;
  logic [SW-1:0]     victim;
  logic [SW-1:0]     mv_slot;
  logic [KeyW-1:0]   mv_key;
  logic [SW-1:0]     a_slot;
  logic [SW-1:0]     b_slot;
  logic              moved;
  logic [CAPACITY-1:0] used;

  // tables
  logic [IdW-1:0]  ids_mem  [CAPACITY];
  logic [KeyW-1:0] keys_mem [CAPACITY];
  logic [SW-1:0]   hord_mem [CAPACITY];
  logic [CW-1:0]   hpos_mem [CAPACITY];

  logic            ids_we, keys_we, hord_we, hpos_we;
  logic [SW-1:0]   ids_wa, keys_wa, hord_wa, hpos_wa;
  logic [IdW-1:0]  ids_wd;
  logic [KeyW-1:0] keys_wd;
  logic [SW-1:0]   hord_wd;
  logic [CW-1:0]   hpos_wd;
  logic [SW-1:0]   ids_ra, keys_ra, keys_rb, hord_ra, hord_rb, hpos_ra;
  logic [IdW-1:0]  ids_q;
  logic [KeyW-1:0] keys_qa, keys_qb;
  logic [SW-1:0]   hord_qa, hord_qb;
  logic [CW-1:0]   hpos_q;

  always_ff @(posedge clk) begin
    if (ids_we) begin
      ids_mem[ids_wa] <= ids_wd;
    end
    ids_q <= ids_mem[ids_ra];
  end

  always_ff @(posedge clk) begin
    if (keys_we) begin
      keys_mem[keys_wa] <= keys_wd;
    end
    keys_qa <= keys_mem[keys_ra];
    keys_qb <= keys_mem[keys_rb];
  end

  always_ff @(posedge clk) begin
    if (hord_we) begin
      hord_mem[hord_wa] <= hord_wd;
    end
    hord_qa <= hord_mem[hord_ra];
    hord_qb <= hord_mem[hord_rb];
  end

  always_ff @(posedge clk) begin
    if (hpos_we) begin
      hpos_mem[hpos_wa] <= hpos_wd;
    end
    hpos_q <= hpos_mem[hpos_ra];
  end

  // compare decisions for the sifts and the scan hit
  logic [CW:0]     j;
  logic [CW:0]     jj;
  logic            pick_b;
  logic            sd_move;
  logic            su_move;
  logic [SW-1:0]   c_slot;
  logic [KeyW-1:0] c_key;
  logic [SW-1:0]   idx;
  logic            hit;

  always_comb begin
    j       = {k, 1'b0};
    pick_b  = (j < {1'b0, count}) && key_gt(keys_qa, keys_qb);
    jj      = pick_b ? j + 1'b1 : j;
    c_slot  = pick_b ? b_slot : a_slot;
    c_key   = pick_b ? keys_qb : keys_qa;
    sd_move = key_gt(mv_key, c_key);
    su_move = key_gt(keys_qa, mv_key);
    idx     = SW'(scan - 1'b1);
    hit     = (scan != '0) && used[idx] && (ids_q == id);
  end

  always_comb begin
    ids_we  = 1'b0;
    ids_wa  = '0;
    ids_wd  = id;
    keys_we = 1'b0;
    keys_wa = '0;
    keys_wd = key;
    hord_we = 1'b0;
    hord_wa = pa({1'b0, k});
    hord_wd = mv_slot;
    hpos_we = 1'b0;
    hpos_wa = mv_slot;
    hpos_wd = k;
    ids_ra  = '0;
    keys_ra = '0;
    keys_rb = '0;
    hord_ra = '0;
    hord_rb = '0;
    hpos_ra = slot;
    unique case (state)
      S_SCAN: ids_ra = scan[SW-1:0];
      S_HIT:  keys_ra = slot;
      S_R1: begin
        keys_we = key_gt(key, keys_qa);
        keys_wa = slot;
      end
      S_U1: hord_ra = pa({1'b0, count});
      S_U2: keys_ra = hord_qa;
      S_MISS: begin
        if (op == OP_SET && count < CW'(CAPACITY)) begin
          ids_we  = 1'b1;
          ids_wa  = free;
          keys_we = 1'b1;
          keys_wa = free;
        end
        hord_ra = pa({{CW{1'b0}}, 1'b1});
        hord_rb = pa({1'b0, count});
      end
      S_V1: begin
        keys_ra = hord_qb;
        ids_ra  = hord_qa;
      end
      S_AP: begin
        ids_we  = 1'b1;
        ids_wa  = victim;
        keys_we = 1'b1;
        keys_wa = victim;
      end
      S_SD0: begin
        hord_ra = pa(j);
        hord_rb = pa(j + 1'b1);
      end
      S_SD1: begin
        keys_ra = hord_qa;
        keys_rb = hord_qb;
      end
      S_SD2: begin
        hord_we = sd_move;
        hord_wd = c_slot;
        hpos_we = sd_move;
        hpos_wa = c_slot;
      end
      S_SU0: hord_ra = pa({2'b0, k[CW-1:1]});
      S_SU1: keys_ra = hord_qa;
      S_SU2: begin
        hord_we = su_move;
        hord_wd = a_slot;
        hpos_we = su_move;
        hpos_wa = a_slot;
      end
      S_FIX: begin
        hord_we = 1'b1;
        hpos_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_NONE;
      used     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= s_tuser;
            id      <= s_tdata[31:0];
            key     <= s_tdata[63:32];
            evicted <= 1'b0;
            evid    <= '0;
            scan    <= '0;
            free_ok <= 1'b0;
            if (s_tuser == OP_CLEAR) begin
              used   <= '0;
              count  <= '0;
              status <= ST_PRESENT;
              state  <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot  <= idx;
            state <= S_HIT;
          end else begin
            if (scan != '0 && !used[idx] && !free_ok) begin
              free    <= idx;
              free_ok <= 1'b1;
            end
            if (scan == CW'(CAPACITY)) begin
              state <= S_MISS;
            end else begin
              scan <= scan + 1'b1;
            end
          end
        end
        S_HIT: begin
          unique case (op)
            OP_SET: state <= S_R1;
            OP_UNSET: begin
              used[slot] <= 1'b0;
              status     <= ST_REMOVED;
              phase      <= PH_UNSET;
              state      <= S_U1;
            end
            default: begin
              status <= ST_PRESENT;
              state  <= S_FIN;
            end
          endcase
        end
        S_R1: begin
          if (key_gt(key, keys_qa)) begin
            mv_slot <= slot;
            mv_key  <= key;
            state   <= S_R2;
          end else begin
            status <= ST_NOT_RAISED;
            state  <= S_FIN;
          end
        end
        S_R2: begin
          k      <= hpos_q;
          phase  <= PH_NONE;
          status <= ST_RAISED;
          state  <= S_SD0;
        end
        S_U1: begin
          k     <= hpos_q;
          state <= S_U2;
        end
        S_U2: begin
          mv_slot <= hord_qa;
          state   <= S_U3;
        end
        S_U3: begin
          mv_key <= keys_qa;
          count  <= count - 1'b1;
          moved  <= 1'b0;
          state  <= (k == count) ? S_FIN : S_SU0;
        end
        S_MISS: begin
          if (op != OP_SET) begin
            status <= ST_NOT_FOUND;
            state  <= S_FIN;
          end else if (count < CW'(CAPACITY)) begin
            used[free] <= 1'b1;
            mv_slot    <= free;
            mv_key     <= key;
            count      <= count + 1'b1;
            k          <= count + 1'b1;
            moved      <= 1'b0;
            phase      <= PH_NONE;
            status     <= ST_INSERTED;
            state      <= S_SU0;
          end else begin
            status  <= ST_REPLACED;
            evicted <= 1'b1;
            state   <= S_V1;
          end
        end
        S_V1: begin
          victim  <= hord_qa;
          mv_slot <= hord_qb;
          state   <= S_V2;
        end
        S_V2: begin
          evid   <= ids_q;
          mv_key <= keys_qa;
          count  <= count - 1'b1;
          k      <= CW'(1);
          phase  <= PH_REPL;
          state  <= S_SD0;
        end
        S_AP: begin
          mv_slot <= victim;
          mv_key  <= key;
          count   <= count + 1'b1;
          k       <= count + 1'b1;
          moved   <= 1'b0;
          phase   <= PH_NONE;
          state   <= S_SU0;
        end
        S_SD0: begin
          state <= (j > {1'b0, count}) ? S_FIX : S_SD1;
        end
        S_SD1: begin
          a_slot <= hord_qa;
          b_slot <= hord_qb;
          state  <= S_SD2;
        end
        S_SD2: begin
          if (sd_move) begin
            k     <= CW'(jj);
            state <= S_SD0;
          end else begin
            state <= S_FIX;
          end
        end
        S_SU0: begin
          if (k <= CW'(1)) begin
            if (phase == PH_UNSET && !moved) begin
              phase <= PH_NONE;
              state <= S_SD0;
            end else begin
              state <= S_FIX;
            end
          end else begin
            state <= S_SU1;
          end
        end
        S_SU1: begin
          a_slot <= hord_qa;
          state  <= S_SU2;
        end
        S_SU2: begin
          if (su_move) begin
            k     <= k >> 1;
            moved <= 1'b1;
            state <= S_SU0;
          end else if (phase == PH_UNSET && !moved) begin
            phase <= PH_NONE;
            state <= S_SD0;
          end else begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= (phase == PH_REPL) ? S_AP : S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {evicted, status};
            m_tdata  <= evid;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_evict_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tuser[2:0] == ST_REPLACED)
    else $error("evicted flag without replace status");

  a_heap_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX |-> k >= CW'(1) && k <= count)
    else $error("heap position out of range");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority page replacer.
// ----------------------------------------------------------------------------
// A directed table covers every opcode and the special cases: raise and
// no-raise, insert, full-table eviction, unset and lookup of absent pages,
// and clear. A random part follows, drawn mostly from a small id pool so
// that pages hit and the table fills. Each request is run through a heap
// model in the bench, and every response is compared with the oldest
// expected one. Sender gaps and receiver stalls vary by phase, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import ppr_pkg::*;

  localparam int Cap = 64;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] id;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    status_t     st;
    logic        ev;
    logic [31:0] ev_id;
  } resp_t;

  typedef struct {
    req_t  rq;
    logic  chk;
    resp_t rs;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;

  priority_page_replacer dut (.*);

  always #2 clk = ~clk;

  // heap model
  logic [31:0] pg_id  [Cap];
  logic        pg_used[Cap];
  logic [31:0] pg_key [Cap];
  int          hp_slot[Cap + 1];
  int          hp_pos [Cap];
  int          n_pages;

  resp_t expected_q[$];
  int    errors = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    hold_off = 0;
  int    quiet = 0;
  logic [31:0] id_pool[16];

  function automatic bit pos_gt(int i, int j);
    return $signed(pg_key[hp_slot[i]]) > $signed(pg_key[hp_slot[j]]);
  endfunction

  function automatic void pos_swap(int i, int j);
    int t;
    t = hp_slot[i];
    hp_slot[i] = hp_slot[j];
    hp_slot[j] = t;
    hp_pos[hp_slot[i]] = i;
    hp_pos[hp_slot[j]] = j;
  endfunction

  function automatic void sift_up(int k);
    while (k > 1 && pos_gt(k / 2, k)) begin
      pos_swap(k, k / 2);
      k = k / 2;
    end
  endfunction

  function automatic void sift_down(int k);
    int j;
    j = 2 * k;
    while (j <= n_pages) begin
      if (j < n_pages && pos_gt(j, j + 1)) j++;
      if (!pos_gt(k, j)) break;
      pos_swap(k, j);
      k = j;
      j = 2 * k;
    end
  endfunction

  function automatic void heap_append(int s, logic [31:0] key);
    n_pages++;
    pg_key[s] = key;
    hp_pos[s] = n_pages;
    hp_slot[n_pages] = s;
    sift_up(n_pages);
  endfunction

  function automatic int find_page(logic [31:0] id);
    for (int i = 0; i < Cap; i++)
      if (pg_used[i] && pg_id[i] == id) return i;
    return -1;
  endfunction

  function automatic resp_t replace_step(req_t r);
    resp_t o;
    int    s;
    int    idx;
    int    victim;
    o = '{st: ST_NOT_FOUND, ev: 1'b0, ev_id: '0};
    case (r.op)
      OP_CLEAR: begin
        for (int i = 0; i < Cap; i++) pg_used[i] = 1'b0;
        n_pages = 0;
        o.st = ST_PRESENT;
      end
      OP_LOOKUP: if (find_page(r.id) >= 0) o.st = ST_PRESENT;
      OP_UNSET: begin
        s = find_page(r.id);
        if (s >= 0) begin
          idx = hp_pos[s];
          if (idx < 1 || idx > n_pages) idx = n_pages;
          pg_used[s] = 1'b0;
          pos_swap(idx, n_pages);
          n_pages--;
          sift_up(idx);
          sift_down(idx);
          o.st = ST_REMOVED;
        end
      end
      default: begin
        s = find_page(r.id);
        if (s >= 0) begin
          if ($signed(r.key) > $signed(pg_key[s])) begin
            pg_key[s] = r.key;
            sift_down(hp_pos[s]);
            o.st = ST_RAISED;
          end else begin
            o.st = ST_NOT_RAISED;
          end
        end else if (n_pages < Cap) begin
          for (s = 0; s < Cap; s++) if (!pg_used[s]) break;
          pg_used[s] = 1'b1;
          pg_id[s] = r.id;
          heap_append(s, r.key);
          o.st = ST_INSERTED;
        end else begin
          victim = hp_slot[1];
          pos_swap(1, n_pages);
          n_pages--;
          sift_down(1);
          o.ev_id = pg_id[victim];
          o.ev = 1'b1;
          pg_id[victim] = r.id;
          pg_used[victim] = 1'b1;
          heap_append(victim, r.key);
          o.st = ST_REPLACED;
        end
      end
    endcase
    return o;
  endfunction

  task automatic send_request(req_t r, logic chk, resp_t want);
    resp_t p;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {r.key, r.id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = replace_step(r);
    if (chk && p != want) begin
      errors++;
      if (errors <= 10)
        $display("table row disagrees with heap model: want %h model %h", want, p);
    end
    expected_q.push_back(p);
    @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // response checker and watchdog
  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (m_tvalid && m_tready) begin
        got = '{st: m_tuser[2:0], ev: m_tuser[3], ev_id: m_tdata};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("response with no request pending: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("response mismatch: status %0d/%0d evicted %0b/%0b id %h/%h",
                       want.st, got.st, want.ev, got.ev, want.ev_id, got.ev_id);
          end
        end
      end
      if (quiet >= WatchdogLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic req_t rand_req();
    req_t r;
    int   k;
    k = $urandom_range(99);
    if (k < 55) r.op = OP_SET;
    else if (k < 75) r.op = OP_UNSET;
    else if (k < 98) r.op = OP_LOOKUP;
    else r.op = OP_CLEAR;
    if ($urandom_range(9) < 7) r.id = id_pool[$urandom_range(15)] + $urandom_range(5);
    else r.id = $urandom;
    case ($urandom_range(5))
      0: r.key = 32'h8000_0000;
      1: r.key = 32'h7fff_ffff;
      2: r.key = $urandom_range(7) << 16;
      default: r.key = $urandom;
    endcase
    return r;
  endfunction

  initial begin
    row_t  rows[$];
    resp_t none;
    req_t  r;
    none = '{st: ST_NOT_FOUND, ev: 1'b0, ev_id: '0};
    n_pages = 0;
    for (int i = 0; i < Cap; i++) pg_used[i] = 1'b0;
    for (int i = 0; i < 16; i++) id_pool[i] = $urandom;

    rows.push_back('{'{OP_LOOKUP, 32'h0, 32'h0}, 1, none});
    rows.push_back('{'{OP_UNSET, 32'hffff_ffff, 32'h0}, 1, none});
    rows.push_back('{'{OP_SET, 32'hffff_ffff, 32'h8000_0000}, 1,
                     '{ST_INSERTED, 1'b0, 32'h0}});
    rows.push_back('{'{OP_SET, 32'hffff_ffff, 32'h8000_0000}, 1,
                     '{ST_NOT_RAISED, 1'b0, 32'h0}});
    rows.push_back('{'{OP_SET, 32'hffff_ffff, 32'h7fff_ffff}, 1,
                     '{ST_RAISED, 1'b0, 32'h0}});
    rows.push_back('{'{OP_LOOKUP, 32'hffff_ffff, 32'h0}, 1,
                     '{ST_PRESENT, 1'b0, 32'h0}});
    rows.push_back('{'{OP_SET, 32'h0, 32'h0001_0000}, 0, none});
    rows.push_back('{'{OP_SET, 32'h0, 32'hffff_0000}, 1,
                     '{ST_NOT_RAISED, 1'b0, 32'h0}});
    rows.push_back('{'{OP_UNSET, 32'hffff_ffff, 32'h0}, 1,
                     '{ST_REMOVED, 1'b0, 32'h0}});
    rows.push_back('{'{OP_CLEAR, 32'h0, 32'h0}, 1, '{ST_PRESENT, 1'b0, 32'h0}});
    rows.push_back('{'{OP_LOOKUP, 32'h0, 32'h0}, 1, none});
    // fill the table, then force evictions
    for (int i = 0; i < Cap + 3; i++)
      rows.push_back('{'{OP_SET, 32'h100 + i, (i % 5) << 16}, 0, none});
    rows.push_back('{'{OP_UNSET, 32'h105, 32'h0}, 0, none});
    rows.push_back('{'{OP_SET, 32'h500, 32'h0}, 0, none});
    rows.push_back('{'{OP_SET, 32'h501, 32'h0}, 0, none});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].rq, rows[i].chk, rows[i].rs);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        3: begin idle_pct = 28; stall_pct = 28; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 84; i++) begin
        r = rand_req();
        send_request(r, 1'b0, none);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

>>> priority_page_replacer.f
src/ppr_pkg.sv
src/priority_page_replacer.sv
dv/testbench.sv
